[hw/rtl/lcc_pkg.sv]
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared types and constants for the fully associative LRU key cache with
// hit and miss cost accounting.
// ----------------------------------------------------------------------------
package lcc_pkg;

  // Cache geometry.
  localparam int WAYS     = 32;
  localparam int KEY_BITS = 64;

  // Width of a way number and of a count that can hold WAYS itself.
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W = $clog2(WAYS + 1);

  // Field widths of the external transactions.
  localparam int ACCESS_KEY_W = 64;
  localparam int WAY_USED_W   = 5;
  localparam int TOTAL_W      = 32;
  localparam int STAMP_W      = 32;
  localparam int ACTIVE_W     = 6;
  localparam int COST_W       = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;

  // Configuration reset values.
  localparam logic [ACTIVE_W-1:0] ACTIVE_WAYS_RST = ACTIVE_W'(32);
  localparam logic [COST_W-1:0]   HIT_COST_RST    = COST_W'(1);
  localparam logic [COST_W-1:0]   MISS_COST_RST   = COST_W'(5);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_WAYS = 2'd0,
    REG_HIT_COST    = 2'd1,
    REG_MISS_COST   = 2'd2
  } cfg_reg_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_FINISH
  } lcc_state_e;

  // Request payload.
  typedef struct packed {
    logic [ACCESS_KEY_W-1:0] access_key;
  } req_t;

  // Response payload.
  typedef struct packed {
    logic                  hit;
    logic [WAY_USED_W-1:0] way_used;
    logic [TOTAL_W-1:0]    total_cost;
  } rsp_t;

  // Configuration write payload.
  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic lookup;
    logic scan;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

[hw/rtl/lcc_chan_if.sv]
// ----------------------------------------------------------------------------
// lcc_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface lcc_chan_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

[hw/rtl/lru_cache_hit_miss_cost.sv]
// ----------------------------------------------------------------------------
// lru_cache_hit_miss_cost
// Fully associative LRU key cache with a saturating hit/miss cost total.
// ----------------------------------------------------------------------------
// Each access key is compared against all active ways in parallel in the
// lookup state. A hit, a fill of the lowest empty way, or a zero configured
// size goes from the lookup state to the finish state, which writes the
// result register. When every active way is full and the key misses, the
// least recently used way is found by a scan that reads one recency stamp
// per cycle over the active ways, whose number N is the active size (at
// most 32). One access is in work at a time; the next key is taken the cycle
// after the previous result is registered, even while that result still waits
// on the output. A result that waits on the output holds the following access
// in its last cycle until the output is free. Configuration writes are
// accepted in any cycle and must only be issued while the block is idle.
module lru_cache_hit_miss_cost (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcc_chan_if.sink    req_i,
  lcc_chan_if.sink    cfg_i,
  lcc_chan_if.source  rsp_o
);

  lcc_pkg::dp_cmd_t    cmd;
  lcc_pkg::dp_status_t status;
  lcc_pkg::req_t       req_payload;
  lcc_pkg::cfg_t       cfg_payload;
  lcc_pkg::rsp_t       rsp_payload;

  assign req_payload   = req_i.payload;
  assign cfg_payload   = cfg_i.payload;
  assign cfg_i.ready   = 1'b1;
  assign rsp_o.payload = rsp_payload;

  // Sequencer.
  lcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Storage and arithmetic.
  lcc_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .access_key_i (req_payload.access_key),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_i        (cfg_payload),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_o        (rsp_payload)
  );

endmodule

[hw/rtl/lcc_ctrl.sv]
// ----------------------------------------------------------------------------
// lcc_ctrl
// Controller state machine: sequences lookup, victim scan and commit for one
// access at a time.
// ----------------------------------------------------------------------------
module lcc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  lcc_pkg::dp_status_t   status_i,
  output lcc_pkg::dp_cmd_t      cmd_o
);

  lcc_pkg::lcc_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      lcc_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lcc_pkg::ST_LOOKUP;
        end
      end
      lcc_pkg::ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = status_i.need_scan ? lcc_pkg::ST_SCAN : lcc_pkg::ST_FINISH;
      end
      lcc_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = lcc_pkg::ST_FINISH;
        end
      end
      lcc_pkg::ST_FINISH: begin
        // Wait until the output register can take the result.
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = lcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lcc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/lcc_dpath.sv]
// ----------------------------------------------------------------------------
// lcc_dpath
// Datapath: configuration registers, tag and recency storage, parallel tag
// compare, sequential LRU victim scan, cost accumulator and output register.
// ----------------------------------------------------------------------------
module lcc_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lcc_pkg::dp_cmd_t                     cmd_i,
  output lcc_pkg::dp_status_t                  status_o,
  input  logic [lcc_pkg::ACCESS_KEY_W-1:0]     access_key_i,
  input  logic                                 cfg_valid_i,
  input  lcc_pkg::cfg_t                        cfg_i,
  input  logic                                 rsp_ready_i,
  output logic                                 rsp_valid_o,
  output lcc_pkg::rsp_t                        rsp_o
);

  // Configuration registers.
  logic [lcc_pkg::ACTIVE_W-1:0] active_ways_q;
  logic [lcc_pkg::COST_W-1:0]   hit_cost_q;
  logic [lcc_pkg::COST_W-1:0]   miss_cost_q;

  // Cache state.
  logic [lcc_pkg::KEY_BITS-1:0] way_tag_q   [lcc_pkg::WAYS];
  logic [lcc_pkg::WAYS-1:0]     way_valid_q;
  logic [lcc_pkg::STAMP_W-1:0]  way_stamp_q [lcc_pkg::WAYS];
  logic [lcc_pkg::STAMP_W-1:0]  access_cnt_q;
  logic [lcc_pkg::TOTAL_W-1:0]  total_q, total_d;

  // Per-access working registers.
  logic [lcc_pkg::KEY_BITS-1:0] key_q;
  logic                         hit_q;
  logic                         empty_q;
  logic                         zero_q;
  logic [lcc_pkg::WAY_W-1:0]    sel_way_q;
  logic [lcc_pkg::WAY_W-1:0]    scan_idx_q;
  logic [lcc_pkg::WAY_W-1:0]    victim_q;
  logic [lcc_pkg::STAMP_W-1:0]  victim_stamp_q;

  // Output register.
  logic          rsp_valid_q;
  lcc_pkg::rsp_t rsp_q;

  // Lookup signals.
  logic [lcc_pkg::CNT_W-1:0] n_ways;
  logic [lcc_pkg::WAYS-1:0]  active;
  logic                      hit_any;
  logic [lcc_pkg::WAY_W-1:0] hit_way;
  logic                      empty_any;
  logic [lcc_pkg::WAY_W-1:0] empty_way;

  // Commit signals.
  logic [lcc_pkg::WAY_W-1:0]                      commit_way;
  logic [lcc_pkg::WAY_W+lcc_pkg::WAY_USED_W-1:0]  way_wide;
  logic [lcc_pkg::COST_W-1:0]                     cost;
  logic [lcc_pkg::TOTAL_W:0]                      sum;
  logic                                           update_ways;

  // Configuration writes; indexes outside the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_ways_q <= lcc_pkg::ACTIVE_WAYS_RST;
      hit_cost_q    <= lcc_pkg::HIT_COST_RST;
      miss_cost_q   <= lcc_pkg::MISS_COST_RST;
    end else if (cfg_valid_i) begin
      unique case (lcc_pkg::cfg_reg_e'(cfg_i.index))
        lcc_pkg::REG_ACTIVE_WAYS: active_ways_q <= cfg_i.data[lcc_pkg::ACTIVE_W-1:0];
        lcc_pkg::REG_HIT_COST:    hit_cost_q    <= cfg_i.data[lcc_pkg::COST_W-1:0];
        lcc_pkg::REG_MISS_COST:   miss_cost_q   <= cfg_i.data[lcc_pkg::COST_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective size, saturated at the number of ways.
  always_comb begin
    if (32'(active_ways_q) > lcc_pkg::WAYS) begin
      n_ways = lcc_pkg::CNT_W'(lcc_pkg::WAYS);
    end else begin
      n_ways = lcc_pkg::CNT_W'(active_ways_q);
    end
  end

  // Ways inside the effective size.
  always_comb begin
    for (int j = 0; j < lcc_pkg::WAYS; j++) begin
      active[j] = (32'(j) < 32'(n_ways));
    end
  end

  // Parallel tag compare and first empty way; the lowest way wins.
  always_comb begin
    hit_any   = 1'b0;
    hit_way   = '0;
    empty_any = 1'b0;
    empty_way = '0;
    for (int j = lcc_pkg::WAYS - 1; j >= 0; j--) begin
      if (active[j] && way_valid_q[j] && (way_tag_q[j] == key_q)) begin
        hit_any = 1'b1;
        hit_way = lcc_pkg::WAY_W'(j);
      end
      if (active[j] && !way_valid_q[j]) begin
        empty_any = 1'b1;
        empty_way = lcc_pkg::WAY_W'(j);
      end
    end
  end

  // Way written on commit, saturating total and the response fields.
  always_comb begin
    commit_way  = (hit_q || empty_q) ? sel_way_q : victim_q;
    way_wide    = {{lcc_pkg::WAY_USED_W{1'b0}}, commit_way};
    cost        = hit_q ? hit_cost_q : miss_cost_q;
    sum         = {1'b0, total_q} + {{(lcc_pkg::TOTAL_W + 1 - lcc_pkg::COST_W){1'b0}}, cost};
    total_d     = sum[lcc_pkg::TOTAL_W] ? '1 : sum[lcc_pkg::TOTAL_W-1:0];
    update_ways = cmd_i.commit && !zero_q;
  end

  // Status to the controller.
  always_comb begin
    status_o.need_scan = (n_ways != '0) && !hit_any && !empty_any;
    status_o.scan_last = (lcc_pkg::CNT_W'(scan_idx_q) == (n_ways - lcc_pkg::CNT_W'(1)));
    status_o.out_free  = !rsp_valid_q || rsp_ready_i;
  end

  // Lookup results, victim scan, recency and cost state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      way_valid_q    <= '0;
      access_cnt_q   <= '0;
      total_q        <= '0;
      hit_q          <= 1'b0;
      empty_q        <= 1'b0;
      zero_q         <= 1'b0;
      sel_way_q      <= '0;
      scan_idx_q     <= '0;
      victim_q       <= '0;
      victim_stamp_q <= '0;
      rsp_valid_q    <= 1'b0;
      for (int j = 0; j < lcc_pkg::WAYS; j++) begin
        way_stamp_q[j] <= '0;
      end
    end else begin
      if (cmd_i.lookup) begin
        hit_q          <= hit_any;
        empty_q        <= !hit_any && empty_any;
        zero_q         <= (n_ways == '0);
        sel_way_q      <= hit_any ? hit_way : empty_way;
        scan_idx_q     <= '0;
        victim_q       <= '0;
        victim_stamp_q <= '1;
      end

      // One way per cycle; ties move the victim to the higher way.
      if (cmd_i.scan) begin
        if (victim_stamp_q >= way_stamp_q[scan_idx_q]) begin
          victim_q       <= scan_idx_q;
          victim_stamp_q <= way_stamp_q[scan_idx_q];
        end
        scan_idx_q <= scan_idx_q + lcc_pkg::WAY_W'(1);
      end

      if (update_ways) begin
        way_stamp_q[commit_way] <= access_cnt_q;
        access_cnt_q            <= access_cnt_q + lcc_pkg::STAMP_W'(1);
        if (!hit_q) begin
          way_valid_q[commit_way] <= 1'b1;
        end
      end

      if (cmd_i.commit) begin
        total_q <= total_d;
      end

      // Output register holds until the sink takes it.
      if (cmd_i.commit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Key capture, tag writes and response payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= access_key_i[lcc_pkg::KEY_BITS-1:0];
    end
    if (update_ways && !hit_q) begin
      way_tag_q[commit_way] <= key_q;
    end
    if (cmd_i.commit) begin
      rsp_q.hit        <= hit_q;
      rsp_q.way_used   <= zero_q ? '0 : way_wide[lcc_pkg::WAY_USED_W-1:0];
      rsp_q.total_cost <= total_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

[hw/rtl/lcc_checker.sv]
// ----------------------------------------------------------------------------
// lcc_checker
// Port-level checks on transaction ordering and the cost total, bound to the
// top level.
// ----------------------------------------------------------------------------
module lcc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_i,
  input logic          rsp_valid_i,
  input logic          rsp_ready_i,
  input lcc_pkg::rsp_t rsp_payload_i
);

  logic                        req_acc;
  logic                        rsp_acc;
  logic [1:0]                  pend_q, pend_d;
  logic [lcc_pkg::TOTAL_W-1:0] last_total_q;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  // Count of accepted requests whose response is not yet delivered.
  always_comb begin
    pend_d = pend_q + (req_acc ? 2'd1 : 2'd0) - (rsp_acc ? 2'd1 : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      last_total_q <= '0;
    end else begin
      pend_q <= pend_d;
      if (rsp_acc) begin
        last_total_q <= rsp_payload_i.total_cost;
      end
    end
  end

  // A stalled response keeps its contents.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_payload_i))
    else $error("response changed while stalled");

  // No response without an outstanding request.
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pend_q != 2'd0)
    else $error("response without an accepted request");

  // At most one access in work and one result waiting.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 |-> !req_acc)
    else $error("request accepted with two results outstanding");

  // The running total never decreases between delivered results.
  a_total_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_acc |-> rsp_payload_i.total_cost >= last_total_q)
    else $error("cost total decreased");

endmodule

bind lru_cache_hit_miss_cost lcc_checker u_lcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_payload_i (rsp_o.payload)
);
